### src/i2cm_pkg.sv
// Shared types, codes and transfer-sequencing functions for the tick-paced I2C master.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Write buffer geometry
   localparam int MaxLen = 64;
   localparam int BufAw  = $clog2(MaxLen);
   localparam int LenW   = 7;

   localparam logic [7:0] TimeoutReset = 8'd100;

   // Request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_BEGIN = 2'd1;
   localparam logic [1:0] REQ_PUSH  = 2'd2;

   // Transaction kinds
   localparam logic [1:0] OP_REG_WRITE  = 2'd0;
   localparam logic [1:0] OP_REG_READ   = 2'd1;
   localparam logic [1:0] OP_CMD16      = 2'd2;
   localparam logic [1:0] OP_PLAIN_READ = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NACK   = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // Bus sequencer states
   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_START = 7'b0000010,
      PH_WBIT  = 7'b0000100,
      PH_ACK   = 7'b0001000,
      PH_RBIT  = 7'b0010000,
      PH_MACK  = 7'b0100000,
      PH_STOP  = 7'b1000000
   } phase_type;

   // Segments of a transaction script
   typedef enum logic [3:0] {
      K_START = 4'd0,
      K_WADDR = 4'd1,
      K_RADDR = 4'd2,
      K_REG   = 4'd3,
      K_HI    = 4'd4,
      K_LO    = 4'd5,
      K_DATA  = 4'd6,
      K_READ  = 4'd7,
      K_STOP  = 4'd8
   } kind_type;

   typedef struct packed {
      logic [1:0]      req_type;
      logic            sda_sample;
      logic [1:0]      op_kind;
      logic [6:0]      device_addr;
      logic [15:0]     reg_or_cmd;
      logic [LenW-1:0] length;
      logic [7:0]      data_byte;
   } req_payload_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       rd_valid;
      logic [7:0] rd_data;
      logic       rd_last;
      logic       done_res;
      logic [1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] stage;
      kind_type   kind;
      logic [7:0] shift;
   } unit_type;

   // Segment at a given stage of the script for one transaction kind
   function automatic kind_type script_kind(input logic [1:0] op, input logic [2:0] stage);
      kind_type k;
      k = K_STOP;
      unique case (op)
         OP_REG_WRITE: begin
            unique case (stage)
               3'd0:    k = K_START;
               3'd1:    k = K_WADDR;
               3'd2:    k = K_REG;
               3'd3:    k = K_DATA;
               default: k = K_STOP;
            endcase
         end
         OP_REG_READ: begin
            unique case (stage)
               3'd0:    k = K_START;
               3'd1:    k = K_WADDR;
               3'd2:    k = K_REG;
               3'd3:    k = K_START;
               3'd4:    k = K_RADDR;
               3'd5:    k = K_READ;
               default: k = K_STOP;
            endcase
         end
         OP_CMD16: begin
            unique case (stage)
               3'd0:    k = K_START;
               3'd1:    k = K_WADDR;
               3'd2:    k = K_HI;
               3'd3:    k = K_LO;
               default: k = K_STOP;
            endcase
         end
         default: begin
            unique case (stage)
               3'd0:    k = K_START;
               3'd1:    k = K_RADDR;
               3'd2:    k = K_READ;
               default: k = K_STOP;
            endcase
         end
      endcase
      return k;
   endfunction

   // Pick the next segment, skipping an exhausted data or read segment, and set up its state.
   // Every script follows a data or read segment with a stop, so one skip is enough.
   function automatic unit_type enter_unit(input logic [1:0]      op,
                                           input logic [2:0]      stage,
                                           input logic [LenW-1:0] byte_index,
                                           input logic [LenW-1:0] len,
                                           input logic [6:0]      addr,
                                           input logic [15:0]     cmd);
      unit_type u;
      kind_type k;
      logic [2:0] st;
      st = stage;
      k  = script_kind(op, st);
      if ((k == K_DATA || k == K_READ) && byte_index >= len) begin
         st = stage + 3'd1;
         k  = script_kind(op, st);
      end
      u.stage = st;
      u.kind  = k;
      u.shift = 8'd0;
      case (k)
         K_START: u.phase = PH_START;
         K_STOP:  u.phase = PH_STOP;
         K_READ:  u.phase = PH_RBIT;
         default: u.phase = PH_WBIT;
      endcase
      case (k)
         K_WADDR: u.shift = {addr, 1'b0};
         K_RADDR: u.shift = {addr, 1'b1};
         K_HI:    u.shift = cmd[15:8];
         K_REG,
         K_LO:    u.shift = cmd[7:0];
         default: u.shift = 8'd0;
      endcase
      return u;
   endfunction

endpackage

### src/i2cm_if.sv
// Channel interfaces: request, response and control-register write.
`timescale 1ns / 1ps

interface i2cm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic        sda_sample;
   logic [1:0]  op_kind;
   logic [6:0]  device_addr;
   logic [15:0] reg_or_cmd;
   logic [6:0]  length;
   logic [7:0]  data_byte;

   modport source (output valid, output req_type, output sda_sample, output op_kind,
                   output device_addr, output reg_or_cmd, output length, output data_byte,
                   input ready);
   modport sink   (input valid, input req_type, input sda_sample, input op_kind,
                   input device_addr, input reg_or_cmd, input length, input data_byte,
                   output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       rd_valid;
   logic [7:0] rd_data;
   logic       rd_last;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, output scl_level, output sda_level, output busy_res,
                   output rd_valid, output rd_data, output rd_last, output done_res,
                   output status, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                   input rd_valid, input rd_data, input rd_last, input done_res,
                   input status, output ready);
endinterface

interface i2cm_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/i2c_master_register_transactions_unit.sv
// Top level of the tick-paced I2C master: control register, sequencer and result register.
//
//   channel | direction | transfer carries
//   --------+-----------+-----------------------------------------------------------
//   req_    | in        | tick with SDA sample, transaction begin, or write-buffer byte
//   rsp_    | out       | line levels, busy, received byte with last mark, done, status
//   csr_    | in        | ack timeout in SDA samples (8 bits, 0 means 256)
//
// One request is taken per cycle and its result is loaded into the result register.
// The sequencer advances one step per tick; all logic for a request sits between the
// sequencer state and the result register, with the write buffer read ahead.
// A stalled response holds the result register and stalls the request channel.
// Reset (synchronous) idles the bus with both lines released and the timeout at 100.
`timescale 1ns / 1ps

module i2c_master_register_transactions_unit (
   input logic        clock,
   input logic        reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan,
   i2cm_csr_if.sink   csr_chan
);

   import i2cm_pkg::*;

   logic            csr_we;
   logic [7:0]      ack_timeout_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type step_rsp;
   req_payload_type step_req;
   logic            step_en;

   // Control register: always ready
   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= TimeoutReset;
      end else if (csr_we) begin
         ack_timeout_ff <= csr_chan.data;
      end
   end

   // Take a request whenever the result register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step_en        = req_chan.valid && req_chan.ready;

   assign step_req.req_type    = req_chan.req_type;
   assign step_req.sda_sample  = req_chan.sda_sample;
   assign step_req.op_kind     = req_chan.op_kind;
   assign step_req.device_addr = req_chan.device_addr;
   assign step_req.reg_or_cmd  = req_chan.reg_or_cmd;
   assign step_req.length      = req_chan.length;
   assign step_req.data_byte   = req_chan.data_byte;

   i2cm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .step_req    (step_req),
      .ack_timeout (ack_timeout_ff),
      .step_rsp    (step_rsp)
   );

   // Result register
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = rsp_data_ff.scl_level;
   assign rsp_chan.sda_level = rsp_data_ff.sda_level;
   assign rsp_chan.busy_res  = rsp_data_ff.busy_res;
   assign rsp_chan.rd_valid  = rsp_data_ff.rd_valid;
   assign rsp_chan.rd_data   = rsp_data_ff.rd_data;
   assign rsp_chan.rd_last   = rsp_data_ff.rd_last;
   assign rsp_chan.done_res  = rsp_data_ff.done_res;
   assign rsp_chan.status    = rsp_data_ff.status;

endmodule

### src/i2cm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module i2cm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/i2cm_ctrl.sv
// Bus sequencer: one step of the I2C line state machine per accepted request.
`timescale 1ns / 1ps

module i2cm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  i2cm_pkg::req_payload_type step_req,
   input  logic [7:0]               ack_timeout,
   output i2cm_pkg::rsp_payload_type step_rsp
);

   import i2cm_pkg::*;

   // Sequencer state
   phase_type       phase_ff, phase_in;
   kind_type        kind_ff, kind_in;
   logic [2:0]      stage_ff, stage_in;
   logic [1:0]      substep_ff, substep_in;
   logic [3:0]      bit_count_ff, bit_count_in;
   logic [7:0]      shift_ff, shift_in;
   logic [LenW-1:0] byte_index_ff, byte_index_in;
   logic [7:0]      ack_wait_ff, ack_wait_in;
   logic [LenW-1:0] pushed_ff, pushed_in;
   logic            failed_ff, failed_in;
   logic            scl_ff, scl_in;
   logic            sda_ff, sda_in;

   // Held request
   logic [1:0]      op_ff, op_in;
   logic [6:0]      addr_ff, addr_in;
   logic [15:0]     cmd_ff, cmd_in;
   logic [LenW-1:0] len_ff, len_in;

   // Buffer access
   logic             buf_we;
   logic [7:0]       buf_q;

   // Scratch for the step
   logic             ent_fire;
   logic [2:0]       ent_stage;
   logic [LenW-1:0]  ent_index;
   unit_type         ent_unit;
   logic             begin_ok;
   logic             last_rd;
   logic [3:0]       bit_inc;
   logic [7:0]       ack_inc;
   logic [7:0]       tx_byte;
   logic [7:0]       rx_byte;
   logic [LenW:0]    index_inc;
   rsp_payload_type  rsp;

   assign bit_inc   = bit_count_ff + 4'd1;
   assign ack_inc   = ack_wait_ff + 8'd1;
   assign index_inc = {1'b0, byte_index_ff} + {{LenW{1'b0}}, 1'b1};
   assign last_rd   = index_inc >= {1'b0, len_ff};
   assign tx_byte   = (kind_ff == K_DATA && bit_count_ff == 4'd0) ? buf_q : shift_ff;
   assign rx_byte   = {shift_ff[6:0], step_req.sda_sample};

   // Next-state and result for one request
   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      stage_in      = stage_ff;
      substep_in    = substep_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      byte_index_in = byte_index_ff;
      ack_wait_in   = ack_wait_ff;
      pushed_in     = pushed_ff;
      failed_in     = failed_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      buf_we        = 1'b0;
      ent_fire      = 1'b0;
      ent_stage     = stage_ff;
      ent_index     = byte_index_ff;
      rsp           = '0;

      case (step_req.op_kind)
         OP_REG_WRITE: begin_ok = step_req.length <= pushed_ff;
         OP_CMD16:     begin_ok = 1'b1;
         default:      begin_ok = step_req.length <= LenW'(MaxLen);
      endcase

      if (step_en) begin
         unique case (step_req.req_type)
            REQ_BEGIN: begin
               if (phase_ff != PH_IDLE || !begin_ok) begin
                  rsp.status = ST_REJECT;
               end else begin
                  op_in     = step_req.op_kind;
                  addr_in   = step_req.device_addr;
                  cmd_in    = step_req.reg_or_cmd;
                  len_in    = step_req.length;
                  pushed_in = '0;
                  failed_in = 1'b0;
                  ent_fire  = 1'b1;
                  ent_stage = 3'd0;
                  ent_index = '0;
               end
            end
            REQ_PUSH: begin
               if (phase_ff != PH_IDLE || pushed_ff >= LenW'(MaxLen)) begin
                  rsp.status = ST_REJECT;
               end else begin
                  buf_we    = 1'b1;
                  pushed_in = pushed_ff + {{(LenW-1){1'b0}}, 1'b1};
               end
            end
            REQ_TICK: begin
               unique case (phase_ff)
                  PH_START: begin
                     substep_in = substep_ff + 2'd1;
                     case (substep_ff)
                        2'd0: sda_in = 1'b1;
                        2'd1: scl_in = 1'b1;
                        2'd2: sda_in = 1'b0;
                        default: begin
                           scl_in    = 1'b0;
                           ent_fire  = 1'b1;
                           ent_stage = stage_ff + 3'd1;
                        end
                     endcase
                  end
                  PH_WBIT: begin
                     case (substep_ff)
                        2'd0: begin
                           sda_in     = tx_byte[7];
                           shift_in   = {tx_byte[6:0], 1'b0};
                           substep_in = 2'd1;
                        end
                        2'd1: begin
                           scl_in     = 1'b1;
                           substep_in = 2'd2;
                        end
                        default: begin
                           scl_in       = 1'b0;
                           bit_count_in = bit_inc;
                           substep_in   = 2'd0;
                           if (bit_inc[3]) begin
                              phase_in    = PH_ACK;
                              ack_wait_in = 8'd0;
                           end
                        end
                     endcase
                  end
                  PH_ACK: begin
                     if (substep_ff == 2'd0) begin
                        sda_in      = 1'b1;
                        scl_in      = 1'b1;
                        ack_wait_in = 8'd0;
                        substep_in  = 2'd1;
                     end else if (!step_req.sda_sample) begin
                        // slave acked: move to the next byte or segment
                        scl_in   = 1'b0;
                        ent_fire = 1'b1;
                        if (kind_ff == K_DATA) begin
                           ent_index = index_inc[LenW-1:0];
                        end else begin
                           ent_stage = stage_ff + 3'd1;
                        end
                     end else if (ack_inc == ack_timeout) begin
                        // give up and go straight to a single stop
                        scl_in     = 1'b0;
                        failed_in  = 1'b1;
                        phase_in   = PH_STOP;
                        substep_in = 2'd0;
                     end else begin
                        ack_wait_in = ack_inc;
                     end
                  end
                  PH_RBIT: begin
                     if (substep_ff == 2'd0) begin
                        sda_in     = 1'b1;
                        scl_in     = 1'b1;
                        substep_in = 2'd1;
                     end else begin
                        shift_in     = rx_byte;
                        scl_in       = 1'b0;
                        bit_count_in = bit_inc;
                        substep_in   = 2'd0;
                        if (bit_inc[3]) begin
                           rsp.rd_valid = 1'b1;
                           rsp.rd_data  = rx_byte;
                           rsp.rd_last  = last_rd;
                           phase_in     = PH_MACK;
                        end
                     end
                  end
                  PH_MACK: begin
                     case (substep_ff)
                        2'd0: begin
                           sda_in     = last_rd;
                           substep_in = 2'd1;
                        end
                        2'd1: begin
                           scl_in     = 1'b1;
                           substep_in = 2'd2;
                        end
                        2'd2: begin
                           scl_in = 1'b0;
                           if (last_rd) begin
                              ent_fire  = 1'b1;
                              ent_index = index_inc[LenW-1:0];
                           end else begin
                              substep_in = 2'd3;
                           end
                        end
                        default: begin
                           sda_in    = 1'b1;
                           ent_fire  = 1'b1;
                           ent_index = index_inc[LenW-1:0];
                        end
                     endcase
                  end
                  PH_STOP: begin
                     case (substep_ff)
                        2'd0: begin
                           sda_in     = 1'b0;
                           substep_in = 2'd1;
                        end
                        2'd1: begin
                           scl_in     = 1'b1;
                           substep_in = 2'd2;
                        end
                        default: begin
                           sda_in       = 1'b1;
                           rsp.done_res = 1'b1;
                           rsp.status   = failed_ff ? ST_NACK : ST_OK;
                           phase_in     = PH_IDLE;
                           substep_in   = 2'd0;
                        end
                     endcase
                  end
                  default: begin
                     // idle: lines hold
                  end
               endcase
            end
            default: begin
               // unused request code: nothing moves
            end
         endcase
      end

      // Enter the next segment of the script
      ent_unit = enter_unit(op_in, ent_stage, ent_index, len_in, addr_in, cmd_in);
      if (ent_fire) begin
         phase_in      = ent_unit.phase;
         stage_in      = ent_unit.stage;
         kind_in       = ent_unit.kind;
         shift_in      = ent_unit.shift;
         byte_index_in = ent_index;
         substep_in    = 2'd0;
         bit_count_in  = 4'd0;
         ack_wait_in   = 8'd0;
      end

      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
      rsp.busy_res  = phase_in != PH_IDLE;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         kind_ff       <= K_START;
         stage_ff      <= '0;
         substep_ff    <= '0;
         bit_count_ff  <= '0;
         byte_index_ff <= '0;
         ack_wait_ff   <= '0;
         pushed_ff     <= '0;
         failed_ff     <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         stage_ff      <= stage_in;
         substep_ff    <= substep_in;
         bit_count_ff  <= bit_count_in;
         byte_index_ff <= byte_index_in;
         ack_wait_ff   <= ack_wait_in;
         pushed_ff     <= pushed_in;
         failed_ff     <= failed_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
      end
   end

   // Shift register and held request
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      cmd_ff   <= cmd_in;
      len_ff   <= len_in;
   end

   // Write buffer; the read side follows the next byte index so its byte is ready next step
   i2cm_ram #(
      .WIDTH (8),
      .DEPTH (MaxLen)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (pushed_ff[BufAw-1:0]),
      .wr_data (step_req.data_byte),
      .rd_addr (byte_index_in[BufAw-1:0]),
      .rd_data (buf_q)
   );

   assign step_rsp = rsp;

endmodule

### src/i2cm_checker.sv
// Port-level checker for the I2C master and its bind to the top level.
`timescale 1ns / 1ps

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       scl_level,
   input logic       sda_level,
   input logic       busy_res,
   input logic       rd_valid,
   input logic [7:0] rd_data,
   input logic       rd_last,
   input logic       done_res,
   input logic [1:0] status
);

   import i2cm_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rd_data) && $stable(status)
                                  && $stable(scl_level) && $stable(sda_level))
      else $error("stalled result changed");

   // Every accepted request yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no result");

   // A received byte only shows inside a transaction with good status
   a_rd_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rd_valid |-> busy_res && !done_res && status == ST_OK)
      else $error("received byte outside a transaction");

   // The last mark never shows without a byte
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rd_last |-> rd_valid)
      else $error("last mark without byte");

   // Completion leaves the bus released and idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res && scl_level && sda_level
                                && (status == ST_OK || status == ST_NACK))
      else $error("completion with bus not released");

endmodule

bind i2c_master_register_transactions_unit i2cm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .scl_level (rsp_chan.scl_level),
   .sda_level (rsp_chan.sda_level),
   .busy_res  (rsp_chan.busy_res),
   .rd_valid  (rsp_chan.rd_valid),
   .rd_data   (rsp_chan.rd_data),
   .rd_last   (rsp_chan.rd_last),
   .done_res  (rsp_chan.done_res),
   .status    (rsp_chan.status)
);

### test/tb_i2c_master_register_transactions_unit.sv
// Testbench for the tick-paced I2C master: directed table, random transactions, line-level predictor.
`timescale 1ns / 1ps

module tb_i2c_master_register_transactions_unit;
   import i2cm_pkg::*;

   // Request code outside the defined set; the block ignores it
   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam int NoNack     = -1;
   localparam int CycleLimit = 1000000;
   localparam int PhaseItems = 100;

   typedef enum logic {ROW_ITEM, ROW_RUN} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
      int              nack_slot;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_chan ();
   i2cm_rsp_if rsp_chan ();
   i2cm_csr_if csr_chan ();

   i2c_master_register_transactions_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Line-level model of the master
   logic [7:0]  ack_limit;
   phase_type   bus_ph;
   logic [2:0]  bus_step;
   logic [3:0]  bit_cnt;
   logic [7:0]  shifter;
   logic [6:0]  byte_idx;
   logic [7:0]  miss_cnt;
   logic [1:0]  txn_op;
   logic [6:0]  txn_addr;
   logic [15:0] txn_cmd;
   logic [6:0]  txn_len;
   logic [7:0]  wr_bytes [MaxLen];
   logic [6:0]  wr_count;
   int          seg_pos;
   kind_type    seg_kind;
   bit          txn_failed;
   logic        scl_q;
   logic        sda_q;
   int          ack_slots;

   kind_type seg_script [4][7] = '{
      '{K_START, K_WADDR, K_REG, K_DATA, K_STOP, K_STOP, K_STOP},
      '{K_START, K_WADDR, K_REG, K_START, K_RADDR, K_READ, K_STOP},
      '{K_START, K_WADDR, K_HI, K_LO, K_STOP, K_STOP, K_STOP},
      '{K_START, K_RADDR, K_READ, K_STOP, K_STOP, K_STOP, K_STOP}
   };

   rsp_payload_type line_rsp_due [$];
   stim_row_type    dir_rows [$];
   int              mismatches = 0;
   int              work_items = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              cycles = 0;

   // Move to the next segment of the script, skipping an exhausted data or read segment
   function automatic void enter_segment();
      kind_type k;
      bit       skip;
      k = K_STOP;
      skip = 1'b1;
      while (skip) begin
         k = (seg_pos < 7) ? seg_script[txn_op][seg_pos] : K_STOP;
         skip = (k == K_DATA || k == K_READ) && (byte_idx >= txn_len);
         if (skip) seg_pos++;
      end
      seg_kind = k;
      bus_step = 3'd0;
      bit_cnt  = 4'd0;
      miss_cnt = 8'd0;
      case (k)
         K_START: bus_ph = PH_START;
         K_STOP:  bus_ph = PH_STOP;
         K_READ: begin
            bus_ph  = PH_RBIT;
            shifter = 8'd0;
         end
         default: begin
            bus_ph = PH_WBIT;
            case (k)
               K_WADDR: shifter = {txn_addr, 1'b0};
               K_RADDR: shifter = {txn_addr, 1'b1};
               K_HI:    shifter = txn_cmd[15:8];
               K_DATA:  shifter = wr_bytes[byte_idx[BufAw-1:0]];
               default: shifter = txn_cmd[7:0];
            endcase
         end
      endcase
   endfunction

   // Apply one request to the model and return the response it must produce
   function automatic rsp_payload_type predict_line_step(input req_payload_type it);
      rsp_payload_type r;
      bit              accept;
      bit              final_byte;
      logic [7:0]      next_miss;
      r = '0;
      final_byte = (int'(byte_idx) + 1 >= int'(txn_len));
      case (it.req_type)
         REQ_BEGIN: begin
            if (bus_ph != PH_IDLE) begin
               r.status = ST_REJECT;
            end else begin
               if (it.op_kind == OP_REG_WRITE) accept = (it.length <= wr_count);
               else if (it.op_kind == OP_CMD16) accept = 1'b1;
               else accept = (it.length <= MaxLen);
               if (!accept) begin
                  r.status = ST_REJECT;
               end else begin
                  txn_op     = it.op_kind;
                  txn_addr   = it.device_addr;
                  txn_cmd    = it.reg_or_cmd;
                  txn_len    = it.length;
                  wr_count   = 7'd0;
                  seg_pos    = 0;
                  byte_idx   = 7'd0;
                  txn_failed = 1'b0;
                  ack_slots  = 0;
                  enter_segment();
               end
            end
         end
         REQ_PUSH: begin
            if (bus_ph != PH_IDLE || wr_count >= MaxLen) begin
               r.status = ST_REJECT;
            end else begin
               wr_bytes[wr_count[BufAw-1:0]] = it.data_byte;
               wr_count++;
            end
         end
         REQ_TICK: begin
            case (bus_ph)
               PH_START: begin
                  case (bus_step)
                     3'd0: begin sda_q = 1'b1; bus_step = 3'd1; end
                     3'd1: begin scl_q = 1'b1; bus_step = 3'd2; end
                     3'd2: begin sda_q = 1'b0; bus_step = 3'd3; end
                     default: begin
                        scl_q = 1'b0;
                        seg_pos++;
                        enter_segment();
                     end
                  endcase
               end
               PH_WBIT: begin
                  if (bus_step == 3'd0) begin
                     sda_q    = shifter[7];
                     shifter  = {shifter[6:0], 1'b0};
                     bus_step = 3'd1;
                  end else if (bus_step == 3'd1) begin
                     scl_q    = 1'b1;
                     bus_step = 3'd2;
                  end else begin
                     scl_q    = 1'b0;
                     bit_cnt++;
                     bus_step = 3'd0;
                     if (bit_cnt >= 4'd8) begin
                        bus_ph   = PH_ACK;
                        miss_cnt = 8'd0;
                        ack_slots++;
                     end
                  end
               end
               PH_ACK: begin
                  next_miss = miss_cnt + 8'd1;
                  if (bus_step == 3'd0) begin
                     sda_q    = 1'b1;
                     scl_q    = 1'b1;
                     miss_cnt = 8'd0;
                     bus_step = 3'd1;
                  end else if (!it.sda_sample) begin
                     scl_q = 1'b0;
                     if (seg_kind == K_DATA) byte_idx++;
                     else seg_pos++;
                     enter_segment();
                  end else if (next_miss == ack_limit) begin
                     // Give up on the slave: one stop follows
                     scl_q      = 1'b0;
                     txn_failed = 1'b1;
                     bus_ph     = PH_STOP;
                     bus_step   = 3'd0;
                  end else begin
                     miss_cnt = next_miss;
                  end
               end
               PH_RBIT: begin
                  if (bus_step == 3'd0) begin
                     sda_q    = 1'b1;
                     scl_q    = 1'b1;
                     bus_step = 3'd1;
                  end else begin
                     shifter  = {shifter[6:0], it.sda_sample};
                     scl_q    = 1'b0;
                     bit_cnt++;
                     bus_step = 3'd0;
                     if (bit_cnt >= 4'd8) begin
                        r.rd_valid = 1'b1;
                        r.rd_data  = shifter;
                        r.rd_last  = final_byte;
                        bus_ph     = PH_MACK;
                     end
                  end
               end
               PH_MACK: begin
                  // Answer the last byte with a nack, every other with an ack
                  case (bus_step)
                     3'd0: begin sda_q = final_byte; bus_step = 3'd1; end
                     3'd1: begin scl_q = 1'b1; bus_step = 3'd2; end
                     3'd2: begin
                        scl_q = 1'b0;
                        if (final_byte) begin
                           byte_idx++;
                           enter_segment();
                        end else begin
                           bus_step = 3'd3;
                        end
                     end
                     default: begin
                        sda_q = 1'b1;
                        byte_idx++;
                        enter_segment();
                     end
                  endcase
               end
               PH_STOP: begin
                  case (bus_step)
                     3'd0: begin sda_q = 1'b0; bus_step = 3'd1; end
                     3'd1: begin scl_q = 1'b1; bus_step = 3'd2; end
                     default: begin
                        sda_q      = 1'b1;
                        r.done_res = 1'b1;
                        r.status   = txn_failed ? ST_NACK : ST_OK;
                        bus_ph     = PH_IDLE;
                        bus_step   = 3'd0;
                     end
                  endcase
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.busy_res  = (bus_ph != PH_IDLE);
      return r;
   endfunction

   function automatic req_payload_type mk_req(input logic [1:0] rt, input logic [1:0] op,
                                              input logic [6:0] addr, input logic [15:0] cmd,
                                              input logic [6:0] len, input logic [7:0] data);
      req_payload_type it;
      it = '0;
      it.req_type    = rt;
      it.op_kind     = op;
      it.device_addr = addr;
      it.reg_or_cmd  = cmd;
      it.length      = len;
      it.data_byte   = data;
      return it;
   endfunction

   // Response of an idle or just-started bus: both lines released
   function automatic rsp_payload_type quiet_rsp(input logic busy, input logic [1:0] st);
      rsp_payload_type r;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      r.busy_res  = busy;
      r.status    = st;
      return r;
   endfunction

   function automatic req_payload_type random_item();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(req_payload_type)-1:0];
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Offer one request, hold it until the transfer, then record the response it must produce
   task automatic send_item(input req_payload_type it, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= it.req_type;
      req_chan.sda_sample  <= it.sda_sample;
      req_chan.op_kind     <= it.op_kind;
      req_chan.device_addr <= it.device_addr;
      req_chan.reg_or_cmd  <= it.reg_or_cmd;
      req_chan.length      <= it.length;
      req_chan.data_byte   <= it.data_byte;
      do @(posedge clock); while (!req_chan.ready);
      if (!(it.req_type == REQ_NONE || (it.req_type == REQ_TICK && bus_ph == PH_IDLE)))
         work_items++;
      got = predict_line_step(it);
      line_rsp_due.push_back(typed ? want : got);
   endtask

   // Tick the bus until the stop completes, playing the slave on SDA; some requests are random noise
   task automatic run_bus(input int nack_slot, input int miss_pct, input int noise_pct);
      req_payload_type it;
      while (bus_ph != PH_IDLE) begin
         it = random_item();
         if ($urandom_range(99) >= noise_pct) begin
            it.req_type = REQ_TICK;
            if (bus_ph == PH_ACK && bus_step != 3'd0)
               it.sda_sample = (ack_slots - 1 == nack_slot) || ($urandom_range(99) < miss_pct);
         end
         send_item(it, 1'b0, '0);
      end
   endtask

   // Fill the buffer as needed, issue one request and run it to the stop
   task automatic run_transaction();
      logic [1:0] op;
      int         len;
      int         npush;
      int         pick;
      int         nack_slot;
      int         miss_pct;
      op   = 2'($urandom_range(3));
      pick = $urandom_range(99);
      len  = (pick < 80) ? $urandom_range(0, 4) :
             (pick < 97) ? $urandom_range(5, 16) : $urandom_range(17, MaxLen);
      npush = 0;
      if (op == OP_REG_WRITE) begin
         npush = len + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
         // Occasionally overrun the buffer
         if ($urandom_range(59) == 0) begin
            npush = MaxLen + 2;
            len   = $urandom_range(17, MaxLen);
         end
      end
      repeat (npush)
         send_item(mk_req(REQ_PUSH, OP_REG_WRITE, 7'd0, 16'd0, 7'd0, 8'($urandom)),
                   1'b0, '0);
      if (op == OP_REG_WRITE && $urandom_range(19) == 0) len = int'(wr_count) + 1;
      if ((op == OP_REG_READ || op == OP_PLAIN_READ) && $urandom_range(24) == 0)
         len = $urandom_range(MaxLen + 1, 127);
      if (op == OP_CMD16) len = $urandom_range(127);
      send_item(mk_req(REQ_BEGIN, op, 7'($urandom), 16'($urandom), 7'(len), 8'($urandom)),
                1'b0, '0);
      nack_slot = ($urandom_range(7) == 0) ? $urandom_range(0, 5) : NoNack;
      case ($urandom_range(2))
         0:       miss_pct = 0;
         1:       miss_pct = 5;
         default: miss_pct = 30;
      endcase
      run_bus(nack_slot, miss_pct, 2);
   endtask

   // Finish the bus activity and wait for every outstanding response
   task automatic settle();
      run_bus(NoNack, 0, 0);
      req_chan.valid <= 1'b0;
      while (line_rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      csr_chan.data  <= value;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      ack_limit = value;
   endtask

   // Response side: random stalls and comparison against the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (line_rsp_due.size() == 0) begin
            $error("response transfer with nothing pending");
            mismatches++;
         end else begin
            want = line_rsp_due.pop_front();
            check_field("scl_level", want.scl_level, rsp_chan.scl_level);
            check_field("sda_level", want.sda_level, rsp_chan.sda_level);
            check_field("busy_res", want.busy_res, rsp_chan.busy_res);
            check_field("rd_valid", want.rd_valid, rsp_chan.rd_valid);
            check_field("rd_data", want.rd_data, rsp_chan.rd_data);
            check_field("rd_last", want.rd_last, rsp_chan.rd_last);
            check_field("done_res", want.done_res, rsp_chan.done_res);
            check_field("status", want.status, rsp_chan.status);
         end
      end
   end

   // Watchdog
   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [7:0] phase_timeout [5];
      int         phase_send [5];
      int         phase_stall [5];
      int         target;
      phase_timeout = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd100};
      phase_send    = '{0, 60, 0, 17, 0};
      phase_stall   = '{0, 0, 60, 17, 0};

      // Model state after reset
      ack_limit  = TimeoutReset;
      bus_ph     = PH_IDLE;
      bus_step   = 3'd0;
      bit_cnt    = 4'd0;
      shifter    = 8'd0;
      byte_idx   = 7'd0;
      miss_cnt   = 8'd0;
      txn_op     = 2'd0;
      txn_addr   = 7'd0;
      txn_cmd    = 16'd0;
      txn_len    = 7'd0;
      wr_count   = 7'd0;
      seg_pos    = 0;
      seg_kind   = K_START;
      txn_failed = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      ack_slots  = 0;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= REQ_TICK;
      req_chan.sda_sample  <= 1'b0;
      req_chan.op_kind     <= OP_REG_WRITE;
      req_chan.device_addr <= 7'd0;
      req_chan.reg_or_cmd  <= 16'd0;
      req_chan.length      <= 7'd0;
      req_chan.data_byte   <= 8'd0;
      csr_chan.valid       <= 1'b0;
      csr_chan.data        <= 8'd0;

      // Directed rows, run at the reset timeout
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_TICK, OP_REG_WRITE, 7'h00, 16'h0000, 7'd0, 8'h00),
                           1'b1, quiet_rsp(1'b0, ST_OK), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_NONE, OP_PLAIN_READ, 7'h7F, 16'hFFFF, 7'd127,
                           8'hFF), 1'b1, quiet_rsp(1'b0, ST_OK), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_WRITE, 7'h10, 16'h0001, 7'd1, 8'h00),
                           1'b1, quiet_rsp(1'b0, ST_REJECT), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_PLAIN_READ, 7'h10, 16'h0001, 7'd65,
                           8'h00), 1'b1, quiet_rsp(1'b0, ST_REJECT), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_READ, 7'h10, 16'h0001, 7'd127,
                           8'h00), 1'b1, quiet_rsp(1'b0, ST_REJECT), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_PUSH, OP_REG_WRITE, 7'h00, 16'h0000, 7'd0, 8'hFF),
                           1'b1, quiet_rsp(1'b0, ST_OK), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_PUSH, OP_REG_WRITE, 7'h00, 16'h0000, 7'd0, 8'h00),
                           1'b1, quiet_rsp(1'b0, ST_OK), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_PUSH, OP_REG_WRITE, 7'h00, 16'h0000, 7'd0, 8'h5A),
                           1'b1, quiet_rsp(1'b0, ST_OK), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_WRITE, 7'h7F, 16'hFFFF, 7'd3, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_CMD16, 7'h01, 16'h1234, 7'd0, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_REJECT), NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_PUSH, OP_REG_WRITE, 7'h00, 16'h0000, 7'd0, 8'h77),
                           1'b1, quiet_rsp(1'b1, ST_REJECT), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_READ, 7'h00, 16'h0000, 7'd64, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, NoNack});
      // Address nack on a command write: the full timeout, then a single stop
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_CMD16, 7'h55, 16'h8001, 7'd127, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, 0});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_PLAIN_READ, 7'h2A, 16'h0000, 7'd0, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_READ, 7'h15, 16'h00AA, 7'd0, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_WRITE, 7'h33, 16'h0042, 7'd0, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, NoNack});
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_PUSH, OP_REG_WRITE, 7'h00, 16'h0000, 7'd0, 8'h3C),
                           1'b1, quiet_rsp(1'b0, ST_OK), NoNack});
      // Data byte nacked after address and register were acked
      dir_rows.push_back('{ROW_ITEM, mk_req(REQ_BEGIN, OP_REG_WRITE, 7'h40, 16'h0012, 7'd1, 8'h00),
                           1'b1, quiet_rsp(1'b1, ST_OK), NoNack});
      dir_rows.push_back('{ROW_RUN, '0, 1'b0, '0, 2});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_RUN) run_bus(dir_rows[i].nack_slot, 20, 0);
         else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random phases, each with its own timeout and idling pattern
      for (int p = 0; p < 5; p++) begin
         settle();
         write_timeout((p == 3) ? 8'($urandom_range(2, 8)) : phase_timeout[p]);
         send_idle_pct = phase_send[p];
         stall_pct     = phase_stall[p];
         target        = work_items + PhaseItems;
         while (work_items < target) begin
            if (bus_ph != PH_IDLE) run_bus(NoNack, 10, 3);
            else if ($urandom_range(99) < 10) send_item(random_item(), 1'b0, '0);
            else run_transaction();
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
